>>> rtl/core/rdc_pkg.sv
package rdc_pkg;

    // Payload of one input transfer
    typedef struct packed {
        logic [31:0] integer_part;
        logic [31:0] fraction_part;
    } in_t;

    // Payload of one output transfer
    typedef struct packed {
        logic [6:0] digit_char;
        logic       digit_valid;
        logic       in_fraction;
        logic       last;
    } out_t;

    // Classification the front attaches to each queued item
    typedef struct packed {
        logic int_zero;   // integer part is zero: no integer digits
        logic frac_go;    // epsilon <= fraction: at least one fraction digit
    } cls_t;

    // Back-end sequencer states
    typedef enum logic [2:0] {
        BK_IDLE,
        BK_DIV,
        BK_INT,
        BK_FRAC,
        BK_MARK
    } bk_state_t;

    // Configuration register indexes
    localparam logic CFG_RADIX   = 1'b0;
    localparam logic CFG_EPSILON = 1'b1;

    localparam logic [5:0]  RADIX_RESET   = 6'd10;
    localparam logic [31:0] EPSILON_RESET = 32'd429497;
    localparam logic [5:0]  RADIX_MIN     = 6'd2;
    localparam logic [5:0]  RADIX_MAX     = 6'd36;

    localparam logic [6:0] DIGIT_ZERO    = 7'h30;
    localparam logic [6:0] DIGIT_ALPHA   = 7'h41;
    localparam logic [5:0] DECIMAL_SPLIT = 6'd10;

    // Quotient bits resolved per divider cycle
    localparam int DIV_BITS = 4;

    // Map a digit value to its ASCII code
    function automatic logic [6:0] to_ascii(input logic [5:0] d);
        logic [6:0] c;
        if (d < DECIMAL_SPLIT)
        begin
            c = DIGIT_ZERO + {1'b0, d};
        end
        else
        begin
            c = DIGIT_ALPHA + {1'b0, d - DECIMAL_SPLIT};
        end
        return c;
    endfunction

endpackage

>>> rtl/core/rdc_front.sv
module rdc_front #(
    parameter int INT_BITS  = 32,
    parameter int FRAC_BITS = 32,
    parameter int ENT_W     = 2 + 6 + INT_BITS + 2 * FRAC_BITS
) (
    input  logic              in_valid,
    output logic              in_ready,
    input  rdc_pkg::in_t      in_data,
    input  logic [5:0]        radix,
    input  logic [31:0]       epsilon,
    input  logic              q_full,
    output logic              q_push,
    output logic [ENT_W-1:0]  q_entry
);

    logic [5:0]           radix_clamped;
    logic [INT_BITS-1:0]  ival;
    logic [FRAC_BITS-1:0] frac_al;
    logic [FRAC_BITS-1:0] eps_al;
    rdc_pkg::cls_t        cls;

    // Bring the Q0.32 inputs to the internal fraction width
    generate
        if (FRAC_BITS > 32)
        begin : g_up
            assign frac_al = {in_data.fraction_part, {(FRAC_BITS - 32){1'b0}}};
            assign eps_al  = {epsilon, {(FRAC_BITS - 32){1'b0}}};
        end
        else if (FRAC_BITS == 32)
        begin : g_same
            assign frac_al = in_data.fraction_part;
            assign eps_al  = epsilon;
        end
        else
        begin : g_down
            assign frac_al = in_data.fraction_part[31 -: FRAC_BITS];
            assign eps_al  = epsilon[31 -: FRAC_BITS];
        end
    endgenerate

    assign ival = in_data.integer_part[INT_BITS-1:0];

    // Clamp the base to the supported range
    always_comb
    begin
        if (radix < rdc_pkg::RADIX_MIN)
        begin
            radix_clamped = rdc_pkg::RADIX_MIN;
        end
        else if (radix > rdc_pkg::RADIX_MAX)
        begin
            radix_clamped = rdc_pkg::RADIX_MAX;
        end
        else
        begin
            radix_clamped = radix;
        end
    end

    // Classify the item for the back end
    assign cls.int_zero = (ival == '0);
    assign cls.frac_go  = (eps_al <= frac_al);

    assign in_ready = !q_full;
    assign q_push   = in_valid && !q_full;
    assign q_entry  = {cls, radix_clamped, ival, frac_al, eps_al};

endmodule

>>> rtl/core/rdc_queue.sv
module rdc_queue #(
    parameter int WIDTH = 8
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             push,
    input  logic [WIDTH-1:0] push_data,
    output logic             full,
    input  logic             pop,
    output logic             not_empty,
    output logic [WIDTH-1:0] pop_data
);

    logic [WIDTH-1:0] mem [2];
    logic             wr_ptr_reg;
    logic             wr_ptr_next;
    logic             rd_ptr_reg;
    logic             rd_ptr_next;
    logic [1:0]       count_reg;
    logic [1:0]       count_next;

    assign full      = (count_reg == 2'd2);
    assign not_empty = (count_reg != 2'd0);
    assign pop_data  = mem[rd_ptr_reg];

    // Advance pointers and occupancy
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg ^ push;
        rd_ptr_next = rd_ptr_reg ^ pop;
        count_next  = count_reg + {1'b0, push} - {1'b0, pop};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Store the entry
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem[wr_ptr_reg] <= push_data;
        end
    end

endmodule

>>> rtl/core/rdc_back.sv
module rdc_back #(
    parameter int INT_BITS       = 32,
    parameter int FRAC_BITS      = 32,
    parameter int FRAC_DIGIT_CAP = 32,
    parameter int ENT_W          = 2 + 6 + INT_BITS + 2 * FRAC_BITS
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             q_valid,
    input  logic [ENT_W-1:0] q_entry,
    output logic             q_pop,
    output logic             out_valid,
    input  logic             out_ready,
    output rdc_pkg::out_t    out_data
);

    localparam int IB_PAD = ((INT_BITS + rdc_pkg::DIV_BITS - 1) / rdc_pkg::DIV_BITS)
                            * rdc_pkg::DIV_BITS;
    localparam int NSTEP  = IB_PAD / rdc_pkg::DIV_BITS;
    localparam int CW     = (NSTEP > 1) ? $clog2(NSTEP) : 1;
    localparam int SPW    = $clog2(INT_BITS + 1);
    localparam int IXW    = $clog2(INT_BITS);
    localparam int FDW    = $clog2(FRAC_DIGIT_CAP + 1);
    localparam int FB     = FRAC_BITS;

    // Entry fields
    rdc_pkg::cls_t       e_cls;
    logic [5:0]          e_radix;
    logic [INT_BITS-1:0] e_ival;
    logic [FB-1:0]       e_frac;
    logic [FB-1:0]       e_eps;

    assign {e_cls, e_radix, e_ival, e_frac, e_eps} = q_entry;

    rdc_pkg::bk_state_t  state_reg;
    rdc_pkg::bk_state_t  state_next;
    logic [5:0]          radix_reg;
    logic [5:0]          radix_next;
    logic [IB_PAD-1:0]   sh_reg;
    logic [IB_PAD-1:0]   sh_next;
    logic [5:0]          rem_reg;
    logic [5:0]          rem_next;
    logic [CW-1:0]       cnt_reg;
    logic [CW-1:0]       cnt_next;
    logic [SPW-1:0]      sp_reg;
    logic [SPW-1:0]      sp_next;
    logic [FB-1:0]       f_reg;
    logic [FB-1:0]       f_next;
    logic [FB:0]         e_reg;
    logic [FB:0]         e_next;
    logic                fgo_reg;
    logic                fgo_next;
    logic [FDW-1:0]      fd_reg;
    logic [FDW-1:0]      fd_next;
    logic                out_valid_reg;
    logic                out_valid_next;
    rdc_pkg::out_t       out_data_reg;
    rdc_pkg::out_t       out_data_next;

    logic [5:0]          stack [INT_BITS];
    logic                push;

    // Divider step results
    logic [IB_PAD-1:0]   div_q;
    logic [5:0]          div_rem;

    // Fraction step results
    logic [FB+5:0]       f_prod;
    logic [FB+6:0]       e_prod;
    logic [FB:0]         e_sat;
    logic [FB-1:0]       f_new;
    logic [5:0]          f_digit;

    logic                slot_free;
    logic [SPW-1:0]      sp_dec;
    logic [SPW-1:0]      sp_next_dec;
    logic [IXW-1:0]      rd_idx;
    logic [5:0]          top_digit_reg;

    localparam logic [FB:0] ONE = {1'b1, {FB{1'b0}}};

    // Resolve DIV_BITS quotient bits of the division by the radix
    always_comb
    begin
        logic [6:0]        t;
        logic [IB_PAD-1:0] q;
        logic [5:0]        rm;
        q  = sh_reg;
        rm = rem_reg;
        for (int i = 0; i < rdc_pkg::DIV_BITS; i++)
        begin
            t = {rm, q[IB_PAD-1]};
            q = {q[IB_PAD-2:0], 1'b0};
            if (t >= {1'b0, radix_reg})
            begin
                t    = t - {1'b0, radix_reg};
                q[0] = 1'b1;
            end
            rm = t[5:0];
        end
        div_q   = q;
        div_rem = rm;
    end

    // One fraction digit: multiply residual and scaled epsilon by the radix
    assign f_prod  = f_reg * radix_reg;
    assign e_prod  = e_reg * radix_reg;
    assign e_sat   = (e_prod > {6'd0, ONE}) ? ONE : e_prod[FB:0];
    assign f_new   = f_prod[FB-1:0];
    assign f_digit = f_prod[FB+5:FB];

    assign slot_free   = !out_valid_reg || out_ready;
    assign sp_dec      = sp_reg - SPW'(1);
    assign sp_next_dec = sp_next - SPW'(1);
    assign rd_idx      = sp_next_dec[IXW-1:0];

    // Sequencer: next state and result generation
    always_comb
    begin
        state_next     = state_reg;
        radix_next     = radix_reg;
        sh_next        = sh_reg;
        rem_next       = rem_reg;
        cnt_next       = cnt_reg;
        sp_next        = sp_reg;
        f_next         = f_reg;
        e_next         = e_reg;
        fgo_next       = fgo_reg;
        fd_next        = fd_reg;
        out_data_next  = out_data_reg;
        out_valid_next = out_valid_reg && !out_ready;
        q_pop          = 1'b0;
        push           = 1'b0;

        case (state_reg)
            rdc_pkg::BK_IDLE:
            begin
                if (q_valid)
                begin
                    q_pop      = 1'b1;
                    radix_next = e_radix;
                    sh_next    = IB_PAD'(e_ival);
                    rem_next   = 6'd0;
                    cnt_next   = '0;
                    sp_next    = '0;
                    f_next     = e_frac;
                    e_next     = {1'b0, e_eps};
                    fgo_next   = e_cls.frac_go;
                    fd_next    = '0;
                    if (!e_cls.int_zero)
                    begin
                        state_next = rdc_pkg::BK_DIV;
                    end
                    else if (e_cls.frac_go)
                    begin
                        state_next = rdc_pkg::BK_FRAC;
                    end
                    else
                    begin
                        state_next = rdc_pkg::BK_MARK;
                    end
                end
            end

            rdc_pkg::BK_DIV:
            begin
                sh_next  = div_q;
                rem_next = div_rem;
                cnt_next = cnt_reg + CW'(1);
                if (cnt_reg == CW'(NSTEP - 1))
                begin
                    // Division done: push the digit, continue on the quotient
                    push     = 1'b1;
                    sp_next  = sp_reg + SPW'(1);
                    rem_next = 6'd0;
                    cnt_next = '0;
                    if (div_q == '0)
                    begin
                        state_next = rdc_pkg::BK_INT;
                    end
                end
            end

            rdc_pkg::BK_INT:
            begin
                if (slot_free)
                begin
                    out_valid_next            = 1'b1;
                    out_data_next.digit_char  = rdc_pkg::to_ascii(top_digit_reg);
                    out_data_next.digit_valid = 1'b1;
                    out_data_next.in_fraction = 1'b0;
                    out_data_next.last        = (sp_dec == '0) && !fgo_reg;
                    sp_next                   = sp_dec;
                    if (sp_dec == '0)
                    begin
                        state_next = fgo_reg ? rdc_pkg::BK_FRAC : rdc_pkg::BK_IDLE;
                    end
                end
            end

            rdc_pkg::BK_FRAC:
            begin
                if (slot_free)
                begin
                    out_valid_next            = 1'b1;
                    out_data_next.digit_char  = rdc_pkg::to_ascii(f_digit);
                    out_data_next.digit_valid = 1'b1;
                    out_data_next.in_fraction = 1'b1;
                    f_next                    = f_new;
                    e_next                    = e_sat;
                    fd_next                   = fd_reg + FDW'(1);
                    // Stop on the cap, a zero residual, or residual below epsilon
                    if ((fd_reg == FDW'(FRAC_DIGIT_CAP - 1)) || (f_new == '0) ||
                        ({1'b0, f_new} < e_sat))
                    begin
                        out_data_next.last = 1'b1;
                        state_next         = rdc_pkg::BK_IDLE;
                    end
                    else
                    begin
                        out_data_next.last = 1'b0;
                    end
                end
            end

            rdc_pkg::BK_MARK:
            begin
                if (slot_free)
                begin
                    out_valid_next            = 1'b1;
                    out_data_next.digit_char  = 7'd0;
                    out_data_next.digit_valid = 1'b0;
                    out_data_next.in_fraction = 1'b0;
                    out_data_next.last        = 1'b1;
                    state_next                = rdc_pkg::BK_IDLE;
                end
            end

            default:
            begin
                state_next = rdc_pkg::BK_IDLE;
            end
        endcase
    end

    // Hold control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= rdc_pkg::BK_IDLE;
            out_valid_reg <= 1'b0;
            sp_reg        <= '0;
            cnt_reg       <= '0;
            fd_reg        <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
            sp_reg        <= sp_next;
            cnt_reg       <= cnt_next;
            fd_reg        <= fd_next;
        end
    end

    // Hold working values and the result
    always_ff @(posedge clk)
    begin
        radix_reg    <= radix_next;
        sh_reg       <= sh_next;
        rem_reg      <= rem_next;
        f_reg        <= f_next;
        e_reg        <= e_next;
        fgo_reg      <= fgo_next;
        out_data_reg <= out_data_next;
        if (push)
        begin
            stack[sp_reg[IXW-1:0]] <= div_rem;
        end
        // Fetch the next top of stack; take a fresh push directly
        top_digit_reg <= push ? div_rem : stack[rd_idx];
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

endmodule

>>> rtl/core/radix_digit_converter_unit.sv
// Converts an unsigned number (integer part plus Q0.32 fraction) into base-radix
// ASCII digits, one output transfer per digit: integer digits most significant
// first without leading zeros, then fraction digits until the residual is zero,
// drops below the scaled epsilon, or FRAC_DIGIT_CAP digits are out; a number
// with no digits gives one empty marker. A front stage clamps the radix, aligns
// the fraction and classifies the item into a two-entry queue, so a new item can
// be accepted while the back end still works. The back end divides the integer
// part by the radix with a single divider that resolves 4 quotient bits per
// cycle, running over the full padded integer width for each integer digit;
// each fraction digit comes from one multiply of the residual by the radix.
// Configuration must be written only while the block is idle; the block
// itself does not enforce this.
module radix_digit_converter_unit #(
    parameter int INT_BITS       = 32,
    parameter int FRAC_BITS      = 32,
    parameter int FRAC_DIGIT_CAP = 32
) (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          in_valid,
    output logic          in_ready,
    input  rdc_pkg::in_t  in_data,
    output logic          out_valid,
    input  logic          out_ready,
    output rdc_pkg::out_t out_data,
    input  logic          cfg_valid,
    output logic          cfg_ready,
    input  logic          cfg_index,
    input  logic [31:0]   cfg_data
);

    localparam int ENT_W = $bits(rdc_pkg::cls_t) + 6 + INT_BITS + 2 * FRAC_BITS;

    logic [5:0]       radix_reg;
    logic [31:0]      epsilon_reg;
    logic             q_full;
    logic             q_push;
    logic [ENT_W-1:0] q_wr_entry;
    logic             q_pop;
    logic             q_not_empty;
    logic [ENT_W-1:0] q_rd_entry;

    assign cfg_ready = 1'b1;

    // Write configuration registers on a transfer
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            radix_reg   <= rdc_pkg::RADIX_RESET;
            epsilon_reg <= rdc_pkg::EPSILON_RESET;
        end
        else if (cfg_valid)
        begin
            case (cfg_index)
                rdc_pkg::CFG_RADIX:   radix_reg   <= cfg_data[5:0];
                rdc_pkg::CFG_EPSILON: epsilon_reg <= cfg_data;
                default:              radix_reg   <= radix_reg;
            endcase
        end
    end

    rdc_front #(
        .INT_BITS  (INT_BITS),
        .FRAC_BITS (FRAC_BITS),
        .ENT_W     (ENT_W)
    ) u_front (
        .in_valid (in_valid),
        .in_ready (in_ready),
        .in_data  (in_data),
        .radix    (radix_reg),
        .epsilon  (epsilon_reg),
        .q_full   (q_full),
        .q_push   (q_push),
        .q_entry  (q_wr_entry)
    );

    rdc_queue #(
        .WIDTH (ENT_W)
    ) u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (q_push),
        .push_data (q_wr_entry),
        .full      (q_full),
        .pop       (q_pop),
        .not_empty (q_not_empty),
        .pop_data  (q_rd_entry)
    );

    rdc_back #(
        .INT_BITS       (INT_BITS),
        .FRAC_BITS      (FRAC_BITS),
        .FRAC_DIGIT_CAP (FRAC_DIGIT_CAP),
        .ENT_W          (ENT_W)
    ) u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .q_valid   (q_not_empty),
        .q_entry   (q_rd_entry),
        .q_pop     (q_pop),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_data  (out_data)
    );

endmodule
